/* hw/rtl/ltz_pkg.sv */
// Shared types, character constants and small conversion helpers for the
// log timestamp zone converter. No dependencies.
package ltz_pkg;

  localparam int unsigned StampLen = 26;
  localparam int unsigned QDepth   = 2;

  localparam logic [7:0] ChOpen    = 8'h5B;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [3:0] ChDigitHi = 4'h3;

  typedef logic [StampLen-1:0][7:0] stamp_t;
  typedef logic [3:0][3:0] year_t;

  typedef struct packed {
    logic       stamp;
    logic [7:0] data;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_stat_t;

  typedef struct packed {
    logic       neg;
    logic [4:0] hrs;
    logic [5:0] mins;
  } zone_cfg_t;

  typedef enum logic [1:0] {
    RegZoneNeg = 2'd0,
    RegZoneHrs = 2'd1,
    RegZoneMin = 2'd2
  } cfg_reg_e;

  // non-digit characters read as zero
  function automatic logic [3:0] digit_val(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) ? c[3:0] : 4'd0;
  endfunction

  function automatic logic [6:0] num2(logic [7:0] a, logic [7:0] b);
    return 7'(digit_val(a)) * 7'd10 + 7'(digit_val(b));
  endfunction

  // exact case-sensitive match, anything else is January
  function automatic logic [3:0] month_code(logic [23:0] s);
    logic [3:0] m;
    unique case (s)
      "Feb":   m = 4'd1;
      "Mar":   m = 4'd2;
      "Apr":   m = 4'd3;
      "May":   m = 4'd4;
      "Jun":   m = 4'd5;
      "Jul":   m = 4'd6;
      "Aug":   m = 4'd7;
      "Sep":   m = 4'd8;
      "Oct":   m = 4'd9;
      "Nov":   m = 4'd10;
      "Dec":   m = 4'd11;
      default: m = 4'd0;
    endcase
    return m;
  endfunction

  function automatic logic [23:0] month_text(logic [3:0] m);
    logic [23:0] s;
    unique case (m)
      4'd1:    s = "Feb";
      4'd2:    s = "Mar";
      4'd3:    s = "Apr";
      4'd4:    s = "May";
      4'd5:    s = "Jun";
      4'd6:    s = "Jul";
      4'd7:    s = "Aug";
      4'd8:    s = "Sep";
      4'd9:    s = "Oct";
      4'd10:   s = "Nov";
      4'd11:   s = "Dec";
      default: s = "Jan";
    endcase
    return s;
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
    logic [4:0] n;
    unique case (m)
      4'd1:                      n = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

  // divisible by 4 depends only on the last two decimal digits
  function automatic logic is_leap(year_t y);
    logic [1:0] s;
    s = y[0][1:0] + {y[1][0], 1'b0};
    return s == 2'd0;
  endfunction

  function automatic year_t bcd_inc(year_t y);
    year_t r;
    logic  c;
    r = y;
    c = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (c) begin
        if (y[i] == 4'd9) begin
          r[i] = 4'd0;
        end else begin
          r[i] = y[i] + 4'd1;
          c    = 1'b0;
        end
      end
    end
    return r;
  endfunction

  function automatic year_t bcd_dec(year_t y);
    year_t r;
    logic  b;
    r = y;
    b = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (b) begin
        if (y[i] == 4'd0) begin
          r[i] = 4'd9;
        end else begin
          r[i] = y[i] - 4'd1;
          b    = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // two decimal digits {tens, ones} of a value below 100
  function automatic logic [7:0] to_dec2(logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  t;
    logic [6:0]  o;
    p = 15'(v) * 15'd205;
    t = p[14:11];
    o = v - 7'(t) * 7'd10;
    return {t, o[3:0]};
  endfunction

endpackage

/* hw/rtl/ltz_in_if.sv */
// Input byte channel of the log timestamp zone converter.
// Plain valid/ready handshake, no dependencies.
interface ltz_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

/* hw/rtl/ltz_out_if.sv */
// Output byte channel of the log timestamp zone converter.
// Plain valid/ready handshake, no dependencies.
interface ltz_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

/* hw/rtl/ltz_front.sv */
// Front end: accepts input bytes, tracks the line phase and collects the
// 26 timestamp bytes. Depends on ltz_pkg and ltz_in_if.
module ltz_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  ltz_in_if.sink           in_i,
  input  ltz_pkg::q_stat_t q_stat_i,
  output ltz_pkg::q_push_t q_push_o,
  output ltz_pkg::stamp_t  stamp_o
);
  import ltz_pkg::*;

  typedef enum logic [2:0] {
    F_SEARCH = 3'b001,
    F_HOLD   = 3'b010,
    F_PASS   = 3'b100
  } fphase_e;

  fphase_e    phase_q, phase_d;
  logic [4:0] cnt_q, cnt_d;
  stamp_t     buf_q;
  logic       accept;

  assign in_i.ready = !q_stat_i.full;
  assign accept     = in_i.valid && in_i.ready;
  assign stamp_o    = buf_q;

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    q_push_o = '0;
    if (accept) begin
      unique case (phase_q)
        F_HOLD: begin
          if (cnt_q == 5'(StampLen - 1)) begin
            // last stamp byte: hand the whole stamp to the back end
            cnt_d                = '0;
            phase_d              = F_PASS;
            q_push_o.valid       = 1'b1;
            q_push_o.entry.stamp = 1'b1;
            q_push_o.entry.data  = in_i.in_byte;
          end else begin
            cnt_d = cnt_q + 5'd1;
          end
        end
        F_SEARCH: begin
          q_push_o.valid      = 1'b1;
          q_push_o.entry.data = in_i.in_byte;
          if (in_i.in_byte == ChOpen) begin
            phase_d = F_HOLD;
            cnt_d   = '0;
          end
        end
        default: begin
          q_push_o.valid      = 1'b1;
          q_push_o.entry.data = in_i.in_byte;
          if (in_i.in_byte == ChNewline) begin
            phase_d = F_SEARCH;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= F_SEARCH;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && phase_q == F_HOLD) begin
      buf_q[cnt_q] <= in_i.in_byte;
    end
  end

endmodule

/* hw/rtl/ltz_queue.sv */
// Two-entry queue between front and back end. Holds plain bytes and
// stamp-complete markers. Depends on ltz_pkg.
module ltz_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ltz_pkg::q_push_t  push_i,
  input  logic              pop_i,
  output ltz_pkg::q_stat_t  stat_o,
  output ltz_pkg::q_entry_t head_o
);
  import ltz_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);

  q_entry_t        mem_q [QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign stat_o.full     = cnt_q == (PtrW + 1)'(QDepth);
  assign stat_o.nonempty = cnt_q != '0;
  assign head_o          = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i.valid) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      priority if (push_i.valid && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i.valid) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_q] <= push_i.entry;
    end
  end

endmodule

/* hw/rtl/ltz_back.sv */
// Back end: passes plain bytes to the output register, converts a complete
// timestamp in its division, minute, hour and date steps and emits its 26 bytes.
// Depends on ltz_pkg and ltz_out_if.
module ltz_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ltz_pkg::q_stat_t   q_stat_i,
  input  ltz_pkg::q_entry_t  head_i,
  output logic               pop_o,
  input  ltz_pkg::stamp_t    stamp_i,
  input  ltz_pkg::zone_cfg_t cfg_i,
  ltz_out_if.source          out_o
);
  import ltz_pkg::*;

  typedef enum logic [5:0] {
    B_PASS = 6'b000001,
    B_DIVM = 6'b000010,
    B_MINS = 6'b000100,
    B_HRS  = 6'b001000,
    B_DATE = 6'b010000,
    B_EMIT = 6'b100000
  } bstate_e;

  bstate_e st_q;
  logic [4:0] idx_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  logic              neg_q;
  logic signed [13:0] tm_q;
  logic [12:0]       mag_q;
  logic [7:0]        qm_q;
  logic signed [8:0] hr_q;
  logic [5:0]        mi_q;
  logic signed [7:0] day_q;
  logic [3:0]        mon_q;
  year_t             yr_q;
  logic [1:0][3:0]   sec_q;
  logic [5:0][7:0]   sep_q;

  logic out_load, emit_byte, pass_byte;

  // load-time parse and zone shift
  logic [13:0]        src_mag, dst_mag;
  logic signed [13:0] t_load;
  // minute division by 60
  logic [13:0]        abs14;
  logic [27:0]        pm;
  logic [12:0]        rm_w;
  logic [5:0]         rm;
  logic signed [8:0]  fq_w;
  logic [5:0]         mi_w;
  // hour division by 24
  logic [8:0]         habs9;
  logic [15:0]        ph;
  logic [3:0]         q24;
  logic [7:0]         r24w;
  logic [4:0]         r24;
  logic signed [4:0]  hq_w;
  logic [6:0]         hrn_w;
  // calendar step
  logic [4:0]         lim, len_dn;
  logic [3:0]         mon_dn;
  year_t              yr_dn;
  // emit
  logic [7:0]  dd, hh, mm, zh, zm;
  logic [23:0] mt;
  logic [7:0]  text;

  assign out_load  = !out_valid_q || out_o.ready;
  assign pop_o     = (st_q == B_PASS) && q_stat_i.nonempty && out_load;
  assign pass_byte = pop_o && !head_i.stamp;
  assign emit_byte = (st_q == B_EMIT) && out_load;

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.run_last = out_last_q;

  always_comb begin
    src_mag = 14'(num2(stamp_i[22], stamp_i[23])) * 14'd60
            + 14'(num2(stamp_i[24], stamp_i[25]));
    dst_mag = 14'(cfg_i.hrs) * 14'd60 + 14'(cfg_i.mins);
    t_load  = $signed(14'(num2(stamp_i[15], stamp_i[16])))
            + ((stamp_i[21] == ChPlus) ? -$signed(src_mag) : $signed(src_mag))
            + (cfg_i.neg ? -$signed(dst_mag) : $signed(dst_mag));
  end

  always_comb begin
    abs14 = tm_q[13] ? 14'(-tm_q) : 14'(tm_q);
    pm    = 28'(abs14[12:0]) * 28'd17477;
    rm_w  = mag_q - 13'(qm_q) * 13'd60;
    rm    = rm_w[5:0];
    // floor division: a negative remainder borrows one more hour
    priority if (neg_q && rm != 6'd0) begin
      fq_w = -$signed({1'b0, qm_q} + 9'd1);
      mi_w = 6'd60 - rm;
    end else if (neg_q) begin
      fq_w = -$signed({1'b0, qm_q});
      mi_w = 6'd0;
    end else begin
      fq_w = $signed({1'b0, qm_q});
      mi_w = rm;
    end
  end

  always_comb begin
    habs9 = hr_q[8] ? 9'(-hr_q) : 9'(hr_q);
    ph    = 16'(habs9[7:0]) * 16'd171;
    q24   = ph[15:12];
    r24w  = habs9[7:0] - 8'(q24) * 8'd24;
    r24   = r24w[4:0];
    // a borrow that leaves the hour non-negative does not wrap it
    priority if (neg_q && !hr_q[8]) begin
      hq_w  = 5'sd0;
      hrn_w = hr_q[6:0];
    end else if (hr_q[8] && r24 != 5'd0) begin
      hq_w  = -$signed({1'b0, q24} + 5'd1);
      hrn_w = 7'(5'd24 - r24);
    end else if (hr_q[8]) begin
      hq_w  = -$signed({1'b0, q24});
      hrn_w = 7'd0;
    end else begin
      hq_w  = $signed({1'b0, q24});
      hrn_w = 7'(r24);
    end
  end

  always_comb begin
    lim    = month_len(mon_q, is_leap(yr_q));
    mon_dn = (mon_q == 4'd0) ? 4'd11 : mon_q - 4'd1;
    yr_dn  = (mon_q == 4'd0) ? bcd_dec(yr_q) : yr_q;
    len_dn = month_len(mon_dn, is_leap(yr_dn));
  end

  always_comb begin
    dd = to_dec2(day_q[6:0]);
    hh = to_dec2(hr_q[6:0]);
    mm = to_dec2({1'b0, mi_q});
    zh = to_dec2({2'b00, cfg_i.hrs});
    zm = to_dec2({1'b0, cfg_i.mins});
    mt = month_text(mon_q);
    unique case (idx_q)
      5'd0:    text = {ChDigitHi, dd[7:4]};
      5'd1:    text = {ChDigitHi, dd[3:0]};
      5'd2:    text = sep_q[0];
      5'd3:    text = mt[23:16];
      5'd4:    text = mt[15:8];
      5'd5:    text = mt[7:0];
      5'd6:    text = sep_q[1];
      5'd7:    text = {ChDigitHi, yr_q[3]};
      5'd8:    text = {ChDigitHi, yr_q[2]};
      5'd9:    text = {ChDigitHi, yr_q[1]};
      5'd10:   text = {ChDigitHi, yr_q[0]};
      5'd11:   text = sep_q[2];
      5'd12:   text = {ChDigitHi, hh[7:4]};
      5'd13:   text = {ChDigitHi, hh[3:0]};
      5'd14:   text = sep_q[3];
      5'd15:   text = {ChDigitHi, mm[7:4]};
      5'd16:   text = {ChDigitHi, mm[3:0]};
      5'd17:   text = sep_q[4];
      5'd18:   text = {ChDigitHi, sec_q[1]};
      5'd19:   text = {ChDigitHi, sec_q[0]};
      5'd20:   text = sep_q[5];
      5'd21:   text = cfg_i.neg ? ChMinus : ChPlus;
      5'd22:   text = {ChDigitHi, zh[7:4]};
      5'd23:   text = {ChDigitHi, zh[3:0]};
      5'd24:   text = {ChDigitHi, zm[7:4]};
      5'd25:   text = {ChDigitHi, zm[3:0]};
      default: text = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= B_PASS;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= pass_byte || emit_byte;
      end
      unique case (st_q)
        B_PASS: if (pop_o && head_i.stamp) st_q <= B_DIVM;
        B_DIVM: st_q <= B_MINS;
        B_MINS: st_q <= B_HRS;
        B_HRS:  st_q <= B_DATE;
        B_DATE: begin
          st_q  <= B_EMIT;
          idx_q <= '0;
        end
        B_EMIT: begin
          if (out_load) begin
            if (idx_q == 5'(StampLen - 1)) begin
              st_q  <= B_PASS;
              idx_q <= '0;
            end else begin
              idx_q <= idx_q + 5'd1;
            end
          end
        end
        default: st_q <= B_PASS;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pass_byte) begin
      out_byte_q <= head_i.data;
      out_last_q <= 1'b1;
    end else if (emit_byte) begin
      out_byte_q <= text;
      out_last_q <= idx_q == 5'(StampLen - 1);
    end
    unique case (st_q)
      B_PASS: begin
        if (pop_o && head_i.stamp) begin
          day_q    <= $signed({1'b0, num2(stamp_i[0], stamp_i[1])});
          mon_q    <= month_code({stamp_i[3], stamp_i[4], stamp_i[5]});
          yr_q[3]  <= digit_val(stamp_i[7]);
          yr_q[2]  <= digit_val(stamp_i[8]);
          yr_q[1]  <= digit_val(stamp_i[9]);
          yr_q[0]  <= digit_val(stamp_i[10]);
          hr_q     <= $signed({2'b00, num2(stamp_i[12], stamp_i[13])});
          tm_q     <= t_load;
          sec_q[1] <= digit_val(stamp_i[18]);
          sec_q[0] <= digit_val(stamp_i[19]);
          sep_q    <= {stamp_i[20], stamp_i[17], stamp_i[14],
                       stamp_i[11], stamp_i[6], stamp_i[2]};
        end
      end
      B_DIVM: begin
        neg_q <= tm_q[13];
        mag_q <= abs14[12:0];
        qm_q  <= pm[27:20];
      end
      B_MINS: begin
        hr_q <= hr_q + fq_w;
        mi_q <= mi_w;
      end
      B_HRS: begin
        hr_q  <= $signed({2'b00, hrn_w});
        day_q <= day_q + {{3{hq_w[4]}}, hq_w};
      end
      B_DATE: begin
        if (neg_q) begin
          if (day_q[7] || day_q == 8'sd0) begin
            mon_q <= mon_dn;
            yr_q  <= yr_dn;
            day_q <= day_q + $signed({3'b000, len_dn});
          end
        end else if (day_q > $signed({3'b000, lim})) begin
          day_q <= day_q - $signed({3'b000, lim});
          if (mon_q == 4'd11) begin
            mon_q <= 4'd0;
            yr_q  <= bcd_inc(yr_q);
          end else begin
            mon_q <= mon_q + 4'd1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/log_timestamp_zone_converter.sv */
// Log timestamp zone converter, top level. Plain bytes pass through a two-entry queue and an
// output register, one byte per cycle while the output is ready. A timestamp's 26 bytes are
// taken one per cycle while the queue has room; after the last one the back end does the
// calendar arithmetic in its division, minute, hour and date steps, then emits 26 bytes, one
// per cycle while the output is ready; input stalls once the queue fills meanwhile.
// Reset clears line phase, counters, queue and zone registers; the stamp buffer is not cleared.
module log_timestamp_zone_converter (
  input  logic       clk_i,
  input  logic       rst_ni,
  ltz_in_if.sink     in_i,
  ltz_out_if.source  out_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [5:0] cfg_data_i
);
  import ltz_pkg::*;

  zone_cfg_t cfg_q;
  q_push_t   q_push;
  q_stat_t   q_stat;
  q_entry_t  q_head;
  logic      q_pop;
  stamp_t    stamp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegZoneNeg: cfg_q.neg  <= cfg_data_i[0];
        RegZoneHrs: cfg_q.hrs  <= cfg_data_i[4:0];
        RegZoneMin: cfg_q.mins <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ltz_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .q_push_o (q_push),
    .stamp_o  (stamp)
  );

  ltz_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .pop_i  (q_pop),
    .stat_o (q_stat),
    .head_o (q_head)
  );

  ltz_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .head_i   (q_head),
    .pop_o    (q_pop),
    .stamp_i  (stamp),
    .cfg_i    (cfg_q),
    .out_o    (out_o)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push.valid |-> !q_stat.full)
    else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_stat.nonempty)
    else $error("queue pop while empty");

  a_burst_unbroken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !out_o.run_last) |=> out_o.valid)
    else $error("gap inside timestamp burst");

endmodule
